/* hdl/htd_pkg.sv */
// ----------------------------------------------------------------------------
// htd_pkg - shared types and constants for the prefix-code tree decoder
// Request and result payloads, status and kind codes, default sizes.
// ----------------------------------------------------------------------------
package htd_pkg;

    localparam int DEF_MAX_NODES    = 512;
    localparam int DEF_MAX_CODE_LEN = 16;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DECODE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [SYM_W-1:0]   symbol;
        logic [CODE_W-1:0]  code_bits;
        logic [LEN_W-1:0]   code_length;
        logic               bit_req;
        logic               flush;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [SYM_W-1:0]   decoded_symbol;
    } t_rsp;

endpackage

/* hdl/htd_node_mem.sv */
// ----------------------------------------------------------------------------
// htd_node_mem - node table memory
// One write port, one registered read port. The root entry reads as zero
// until it is first written.
// ----------------------------------------------------------------------------
module htd_node_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 27
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic          r_root_valid;
    logic          r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    // track the root write; a read of the root before then returns zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_valid <= 1'b0;
            r_rd_zero    <= 1'b0;
        end else begin
            if (i_we && (i_wr_addr == '0)) begin
                r_root_valid <= 1'b1;
            end
            r_rd_zero <= (i_rd_addr == '0) && !r_root_valid;
        end
    end

    assign o_rd_data = r_rd_zero ? '0 : r_rd_data;

endmodule

/* hdl/huffman_tree_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_tree_decoder - prefix-code decoder on a node table
// Inserts build the code tree in node memory; decodes walk it one bit a request.
// ----------------------------------------------------------------------------
// Decode: a cached current node goes straight to S_DEC_CHK; after reset, a symbol,
//   a missing branch, a flush or an insert the node is first reread in S_DEC_CUR.
//   A missing branch skips S_DEC_CHK (busy stays low on a cached node).
// Insert: each code bit is one node memory read and, for
//   a new child, one write back on the separate write port. Results cannot be stalled.
// Reset (synchronous, active low) clears the walker, the node count and the root.
module huffman_tree_decoder
    import htd_pkg::*;
#(
    parameter int MAX_NODES    = DEF_MAX_NODES,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    // node index, node count and code step widths
    localparam int IW      = $clog2(MAX_NODES);
    localparam int UW      = $clog2(MAX_NODES + 1);
    localparam int KW      = $clog2(MAX_CODE_LEN + 1);
    // entry layout: leaf | symbol | child 1 | child 0
    localparam int ENTRY_W = 1 + SYM_W + 2 * IW;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_INS_STEP = 6'b000010,
        S_INS_CHK  = 6'b000100,
        S_INS_LEAF = 6'b001000,
        S_DEC_CUR  = 6'b010000,
        S_DEC_CHK  = 6'b100000
    } t_state;

    function automatic logic [IW-1:0] f_kid(input logic [ENTRY_W-1:0] e, input logic b);
        return b ? e[2*IW-1:IW] : e[IW-1:0];
    endfunction

    function automatic logic [ENTRY_W-1:0] f_set_kid(input logic [ENTRY_W-1:0] e,
                                                     input logic b,
                                                     input logic [IW-1:0] k);
        logic [ENTRY_W-1:0] r;
        r = e;
        if (b) begin
            r[2*IW-1:IW] = k;
        end else begin
            r[IW-1:0] = k;
        end
        return r;
    endfunction

    t_state               r_state, n_state;
    logic [UW-1:0]        r_nodes_used, n_nodes_used;
    logic [IW-1:0]        r_walk, n_walk;
    logic                 r_cache_valid, n_cache_valid;
    logic [ENTRY_W-1:0]   r_cache, n_cache;
    logic [IW-1:0]        r_cur, n_cur;
    logic [IW-1:0]        r_nxt, n_nxt;
    logic                 r_fresh, n_fresh;
    logic [KW-1:0]        r_k, n_k;
    logic [CODE_W-1:0]    r_code, n_code;
    logic [SYM_W-1:0]     r_sym, n_sym;
    logic                 r_bit, n_bit;
    logic                 r_flush, n_flush;
    logic                 r_out_valid, n_out_valid;
    t_rsp                 r_out, n_out;

    logic [IW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   rd_entry;
    logic                 we;
    logic [IW-1:0]        wr_addr;
    logic [ENTRY_W-1:0]   wr_data;

    htd_node_mem #(
        .DEPTH (MAX_NODES),
        .AW    (IW),
        .DW    (ENTRY_W)
    ) u_node_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        logic               fin;
        logic               fl;
        logic [ENTRY_W-1:0] e;
        logic [IW-1:0]      kid;
        logic               bit_sel;
        logic [5:0]         idx6;
        logic [5:0]         len6;

        n_state       = r_state;
        n_nodes_used  = r_nodes_used;
        n_walk        = r_walk;
        n_cache_valid = r_cache_valid;
        n_cache       = r_cache;
        n_cur         = r_cur;
        n_nxt         = r_nxt;
        n_fresh       = r_fresh;
        n_k           = r_k;
        n_code        = r_code;
        n_sym         = r_sym;
        n_bit         = r_bit;
        n_flush       = r_flush;
        n_out_valid   = 1'b0;
        n_out         = r_out;
        rd_addr       = r_walk;
        we            = 1'b0;
        wr_addr       = r_cur;
        wr_data       = '0;
        fin           = 1'b0;
        fl            = 1'b0;
        e             = '0;
        kid           = '0;
        idx6          = 6'(r_k) - 6'd1;
        bit_sel       = (idx6 < 6'(CODE_W)) ? r_code[idx6[3:0]] : 1'b0;
        len6          = {1'b0, i_req.code_length};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_flush = i_req.flush;
                    n_bit   = i_req.bit_req;
                    n_sym   = i_req.symbol;
                    n_code  = i_req.code_bits;
                    if (i_req.kind == KIND_INSERT) begin
                        // any insert may rewrite the node under the walker
                        n_cache_valid = 1'b0;
                        if (i_req.code_length == '0) begin
                            fin = 1'b1;
                            fl  = i_req.flush;
                        end else begin
                            // clip the walk to the longest supported code
                            n_k     = (len6 > 6'(MAX_CODE_LEN)) ? KW'(MAX_CODE_LEN)
                                                                : KW'(len6);
                            n_cur   = '0;
                            n_fresh = 1'b0;
                            n_state = S_INS_STEP;
                        end
                    end else if (r_cache_valid) begin
                        kid = f_kid(r_cache, i_req.bit_req);
                        if (kid == '0) begin
                            n_out_valid   = 1'b1;
                            n_out         = '{status: ST_MISSING, decoded_symbol: '0};
                            n_walk        = '0;
                            n_cache_valid = 1'b0;
                            fin           = 1'b1;
                            fl            = i_req.flush;
                        end else begin
                            rd_addr = kid;
                            n_nxt   = kid;
                            n_state = S_DEC_CHK;
                        end
                    end else begin
                        rd_addr = r_walk;
                        n_state = S_DEC_CUR;
                    end
                end
            end

            S_INS_STEP: begin
                rd_addr = r_cur;
                n_state = S_INS_CHK;
            end

            S_INS_CHK: begin
                // a node created on the previous step is known to be empty
                e   = r_fresh ? '0 : rd_entry;
                kid = f_kid(e, bit_sel);
                if (kid != '0) begin
                    n_cur   = kid;
                    n_fresh = 1'b0;
                    n_k     = r_k - KW'(1);
                    n_state = (r_k == KW'(1)) ? S_INS_LEAF : S_INS_STEP;
                end else if (r_nodes_used >= UW'(MAX_NODES)) begin
                    // table full: commit the empty node already linked in
                    if (r_fresh) begin
                        we      = 1'b1;
                        wr_addr = r_cur;
                        wr_data = '0;
                    end
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_FULL, decoded_symbol: '0};
                    fin         = 1'b1;
                    fl          = r_flush;
                end else begin
                    // link a new child and write the parent back
                    we           = 1'b1;
                    wr_addr      = r_cur;
                    wr_data      = f_set_kid(e, bit_sel, r_nodes_used[IW-1:0]);
                    n_cur        = r_nodes_used[IW-1:0];
                    n_nodes_used = r_nodes_used + UW'(1);
                    n_fresh      = 1'b1;
                    n_k          = r_k - KW'(1);
                    n_state      = (r_k == KW'(1)) ? S_INS_LEAF : S_INS_STEP;
                end
            end

            S_INS_LEAF: begin
                we      = 1'b1;
                wr_addr = r_cur;
                wr_data = {1'b1, r_sym, {(2*IW){1'b0}}};
                fin     = 1'b1;
                fl      = r_flush;
            end

            S_DEC_CUR: begin
                kid = f_kid(rd_entry, r_bit);
                if (kid == '0) begin
                    n_out_valid   = 1'b1;
                    n_out         = '{status: ST_MISSING, decoded_symbol: '0};
                    n_walk        = '0;
                    n_cache_valid = 1'b0;
                    fin           = 1'b1;
                    fl            = r_flush;
                end else begin
                    rd_addr = kid;
                    n_nxt   = kid;
                    n_state = S_DEC_CHK;
                end
            end

            S_DEC_CHK: begin
                if (rd_entry[ENTRY_W-1]) begin
                    n_out_valid   = 1'b1;
                    n_out         = '{status: ST_OK,
                                      decoded_symbol: rd_entry[ENTRY_W-2 -: SYM_W]};
                    n_walk        = '0;
                    n_cache_valid = 1'b0;
                end else begin
                    // advance and keep the new node for the next bit
                    n_walk        = r_nxt;
                    n_cache       = rd_entry;
                    n_cache_valid = 1'b1;
                end
                fin = 1'b1;
                fl  = r_flush;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
            if (fl) begin
                n_walk        = '0;
                n_cache_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_nodes_used  <= UW'(1);
            r_walk        <= '0;
            r_cache_valid <= 1'b0;
            r_fresh       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_nodes_used  <= n_nodes_used;
            r_walk        <= n_walk;
            r_cache_valid <= n_cache_valid;
            r_fresh       <= n_fresh;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_cache <= n_cache;
        r_cur   <= n_cur;
        r_nxt   <= n_nxt;
        r_k     <= n_k;
        r_code  <= n_code;
        r_sym   <= n_sym;
        r_bit   <= n_bit;
        r_flush <= n_flush;
        r_out   <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_valid;
    assign o_rsp    = r_out;

`ifndef SYNTH
    a_nodes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used >= UW'(1)) && (r_nodes_used <= UW'(MAX_NODES)))
        else $error("node count out of range");

    a_full_only_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_rsp.status == ST_FULL)) |-> (r_nodes_used == UW'(MAX_NODES)))
        else $error("table full reported below the node limit");

    a_cache_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cache_valid |-> (r_walk != '0))
        else $error("cached walker entry at the root");

    a_cur_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS_CHK) || (r_state == S_INS_LEAF)) |-> (UW'(r_cur) < r_nodes_used))
        else $error("insert walker on an unallocated node");

    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS_STEP) || (r_state == S_INS_CHK)) |-> (r_k != '0))
        else $error("insert step with no code bits left");
`endif

endmodule
